FILE: src/scmp_pkg.sv
// shared constants, microcode format and microcode program of the s-curve planner
package scmp_pkg;

  localparam int CALC_W     = 48;
  localparam int DIV_W      = 24;
  localparam int CNT_W      = 6;
  localparam int PC_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JERK_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPU       = 3'd4;

  localparam int RST_MIN_RATE  = 1000;
  localparam int RST_MAX_RATE  = 150000;
  localparam int RST_MAX_ACCEL = 5000;
  localparam int RST_JERK_STEP = 1;
  localparam int RST_SPU       = 200;
  localparam int SPU_MIN       = 10;

  localparam logic [2:0] PH_J1     = 3'd0;
  localparam logic [2:0] PH_A1     = 3'd1;
  localparam logic [2:0] PH_J2     = 3'd2;
  localparam logic [2:0] PH_CRUISE = 3'd3;
  localparam logic [2:0] PH_J3     = 3'd4;
  localparam logic [2:0] PH_A2     = 3'd5;
  localparam logic [2:0] PH_J4     = 3'd6;
  localparam logic [2:0] PH_TAIL   = 3'd7;

  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_DIV_UPD   = 5'd2;
  localparam logic [4:0] OP_GET_UPD   = 5'd3;
  localparam logic [4:0] OP_DIV_NJ    = 5'd4;
  localparam logic [4:0] OP_GET_NJ    = 5'd5;
  localparam logic [4:0] OP_MUL_NN    = 5'd6;
  localparam logic [4:0] OP_TRI       = 5'd7;
  localparam logic [4:0] OP_D         = 5'd8;
  localparam logic [4:0] OP_MUL_NAMAX = 5'd9;
  localparam logic [4:0] OP_MARGIN    = 5'd10;
  localparam logic [4:0] OP_ROOM      = 5'd11;
  localparam logic [4:0] OP_DIV_ROOM  = 5'd12;
  localparam logic [4:0] OP_GET_NA    = 5'd13;
  localparam logic [4:0] OP_NA_FLAT   = 5'd14;
  localparam logic [4:0] OP_MUL_NAD   = 5'd15;
  localparam logic [4:0] OP_MUL_ND    = 5'd16;
  localparam logic [4:0] OP_F2        = 5'd17;
  localparam logic [4:0] OP_F3        = 5'd18;
  localparam logic [4:0] OP_F4        = 5'd19;
  localparam logic [4:0] OP_F5        = 5'd20;
  localparam logic [4:0] OP_EMIT      = 5'd21;

  localparam logic [2:0] COND_NEVER     = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_NO_REQ    = 3'd2;
  localparam logic [2:0] COND_DIV_BUSY  = 3'd3;
  localparam logic [2:0] COND_SHORT     = 3'd4;
  localparam logic [2:0] COND_D_ZERO    = 3'd5;
  localparam logic [2:0] COND_EMIT_MORE = 3'd6;

  localparam logic [PC_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] ST_WAIT_U  = 5'd2;
  localparam logic [PC_W-1:0] ST_WAIT_J  = 5'd6;
  localparam logic [PC_W-1:0] ST_WAIT_R  = 5'd16;
  localparam logic [PC_W-1:0] ST_FLAT    = 5'd18;
  localparam logic [PC_W-1:0] ST_NAD     = 5'd19;
  localparam logic [PC_W-1:0] ST_EMIT    = 5'd25;

  typedef struct packed {
    logic [4:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = '{OP_LOAD,      COND_NO_REQ,    ST_IDLE};
      5'd1:    w = '{OP_DIV_UPD,   COND_NEVER,     ST_IDLE};
      5'd2:    w = '{OP_NOP,       COND_DIV_BUSY,  ST_WAIT_U};
      5'd3:    w = '{OP_GET_UPD,   COND_NEVER,     ST_IDLE};
      5'd4:    w = '{OP_NOP,       COND_SHORT,     ST_EMIT};
      5'd5:    w = '{OP_DIV_NJ,    COND_NEVER,     ST_IDLE};
      5'd6:    w = '{OP_NOP,       COND_DIV_BUSY,  ST_WAIT_J};
      5'd7:    w = '{OP_GET_NJ,    COND_NEVER,     ST_IDLE};
      5'd8:    w = '{OP_MUL_NN,    COND_NEVER,     ST_IDLE};
      5'd9:    w = '{OP_TRI,       COND_NEVER,     ST_IDLE};
      5'd10:   w = '{OP_D,         COND_NEVER,     ST_IDLE};
      5'd11:   w = '{OP_MUL_NAMAX, COND_NEVER,     ST_IDLE};
      5'd12:   w = '{OP_MARGIN,    COND_NEVER,     ST_IDLE};
      5'd13:   w = '{OP_ROOM,      COND_NEVER,     ST_IDLE};
      5'd14:   w = '{OP_NOP,       COND_D_ZERO,    ST_FLAT};
      5'd15:   w = '{OP_DIV_ROOM,  COND_NEVER,     ST_IDLE};
      5'd16:   w = '{OP_NOP,       COND_DIV_BUSY,  ST_WAIT_R};
      5'd17:   w = '{OP_GET_NA,    COND_ALWAYS,    ST_NAD};
      5'd18:   w = '{OP_NA_FLAT,   COND_NEVER,     ST_IDLE};
      5'd19:   w = '{OP_MUL_NAD,   COND_NEVER,     ST_IDLE};
      5'd20:   w = '{OP_MUL_ND,    COND_NEVER,     ST_IDLE};
      5'd21:   w = '{OP_F2,        COND_NEVER,     ST_IDLE};
      5'd22:   w = '{OP_F3,        COND_NEVER,     ST_IDLE};
      5'd23:   w = '{OP_F4,        COND_NEVER,     ST_IDLE};
      5'd24:   w = '{OP_F5,        COND_NEVER,     ST_IDLE};
      5'd25:   w = '{OP_EMIT,      COND_EMIT_MORE, ST_EMIT};
      5'd26:   w = '{OP_NOP,       COND_ALWAYS,    ST_IDLE};
      default: w = '{OP_NOP,       COND_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: src/scmp_cfg_if.sv
// configuration write channel of the s-curve planner
interface scmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/scmp_req_if.sv
// move request channel of the s-curve planner
interface scmp_req_if #(
  parameter int STEP_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [STEP_BITS-1:0] total_step_count;
  logic                 move_direction;

  modport source (output valid, total_step_count, move_direction, input ready);
  modport sink (input valid, total_step_count, move_direction, output ready);
endinterface

FILE: src/scmp_phase_if.sv
// planned phase result channel of the s-curve planner
interface scmp_phase_if #(
  parameter int STEP_BITS = 32,
  parameter int RATE_BITS = 21
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  phase_code;
  logic [RATE_BITS-1:0]        start_rate;
  logic signed [16:0]          start_accel;
  logic signed [8:0]           phase_jerk;
  logic [STEP_BITS-1:0]        update_count;
  logic                        tail_present;
  logic                        direction_out;
  logic                        last_phase;

  modport source (
    output valid, phase_code, start_rate, start_accel, phase_jerk, update_count,
           tail_present, direction_out, last_phase,
    input  ready
  );
  modport sink (
    input  valid, phase_code, start_rate, start_accel, phase_jerk, update_count,
           tail_present, direction_out, last_phase,
    output ready
  );
endinterface

FILE: src/s_curve_motion_planner_core.sv
// s-curve motion planner: microcoded sequencer with shared iterative divider
//
// cfg takes register writes (index 0 min_rate .. 4 steps_per_update) at any
// edge with valid high; ready is high whenever rst is low. writes belong
// between moves.
// req takes one move request (step count, direction) while the sequencer is
// idle. phase returns eight transfers per request, J1 through J4 then the
// tail, the tail flagged by last_phase.
// a request runs through a 27-step microprogram; it divides on the shared
// restoring divider of 48 quotient bits, skips the room division when A1
// has no rate change and jumps straight to the emit step for a move with no
// whole update. with phase ready held high the eight phases leave on
// consecutive cycles, and req is ready again once the sequencer has passed
// from its emit step through its final step back to idle.
// a held phase ready freezes the sequencer in its emit step; the phase
// output register holds its transfer until taken.
// reset (rst, synchronous) restores the register defaults, empties the
// output register and returns the sequencer to idle.
module s_curve_motion_planner_core #(
  parameter int STEP_BITS = 32,
  parameter int RATE_BITS = 21
) (
  input  logic         clk,
  input  logic         rst,
  scmp_cfg_if.sink     cfg,
  scmp_req_if.sink     req,
  scmp_phase_if.source phase
);
  import scmp_pkg::*;

  localparam int SX_W = STEP_BITS + 2;

  logic [RATE_BITS-1:0] min_rate;
  logic [RATE_BITS-1:0] max_rate;
  logic [15:0]          max_accel;
  logic [7:0]           jerk_step;
  logic [7:0]           steps_per_update;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          uc;
  logic            cond_true;

  logic [CALC_W-1:0] div_q;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  div_d;
  logic [CNT_W-1:0]  div_cnt;
  logic              div_busy;
  logic [DIV_W:0]    div_trial;
  logic              div_start;
  logic [CALC_W-1:0] div_a_in;
  logic [DIV_W-1:0]  div_d_in;

  logic [STEP_BITS-1:0] steps;
  logic                 dir;
  logic [STEP_BITS-1:0] upd;
  logic [7:0]           rem;
  logic                 short_move;
  logic [15:0]          nj;
  logic [31:0]          nn;
  logic [CALC_W-1:0]    tri_sum;
  logic [23:0]          dval;
  logic [31:0]          namax;
  logic [CALC_W-1:0]    margin;
  logic [CALC_W-1:0]    f1;
  logic [CALC_W-1:0]    room;
  logic [STEP_BITS-1:0] nb;
  logic [STEP_BITS-1:0] na;
  logic [CALC_W-1:0]    nad;
  logic [CALC_W-1:0]    nd;
  logic [CALC_W-1:0]    f2;
  logic [CALC_W-1:0]    f3;
  logic [CALC_W-1:0]    f4;
  logic [CALC_W-1:0]    f5;
  logic [STEP_BITS-1:0] nc;

  logic [7:0]  spu;
  logic [7:0]  jv;
  logic [15:0] nm1;

  logic [31:0]            nn_prod;
  logic [38:0]            tri_prod;
  logic [23:0]            d_prod;
  logic [31:0]            namax_prod;
  logic [STEP_BITS+23:0]  nad_prod;
  logic [39:0]            nd_prod;

  logic [SX_W-1:0] upd_x;
  logic [SX_W-1:0] used_x;
  logic [SX_W-1:0] qb_x;
  logic [SX_W-1:0] nb_x;
  logic [SX_W-1:0] acc_x;

  logic [2:0]            ph;
  logic                  emit_load;
  logic                  out_valid;
  logic [2:0]            out_code;
  logic [RATE_BITS-1:0]  out_rate;
  logic [16:0]           out_accel;
  logic [8:0]            out_jerk;
  logic [STEP_BITS-1:0]  out_count;
  logic                  out_tail;
  logic                  out_dir;
  logic                  out_last;

  logic [CALC_W-1:0]     sel_rate;
  logic [16:0]           sel_accel;
  logic [8:0]            sel_jerk;
  logic [STEP_BITS-1:0]  sel_count;
  logic [16:0]           d_pos;
  logic [16:0]           d_neg;
  logic [8:0]            j_pos;
  logic [8:0]            j_neg;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate         <= RATE_BITS'(RST_MIN_RATE);
      max_rate         <= RATE_BITS'(RST_MAX_RATE);
      max_accel        <= 16'(RST_MAX_ACCEL);
      jerk_step        <= 8'(RST_JERK_STEP);
      steps_per_update <= 8'(RST_SPU);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_RATE:  min_rate         <= cfg.data[RATE_BITS-1:0];
        CFG_MAX_RATE:  max_rate         <= cfg.data[RATE_BITS-1:0];
        CFG_MAX_ACCEL: max_accel        <= cfg.data[15:0];
        CFG_JERK_STEP: jerk_step        <= cfg.data[7:0];
        CFG_SPU:       steps_per_update <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign spu = (steps_per_update < 8'(SPU_MIN)) ? 8'(SPU_MIN) : steps_per_update;
  assign jv  = (jerk_step == 8'd0) ? 8'd1 : jerk_step;

  // sequencer
  assign uc        = ucode_rom(pc);
  assign emit_load = !out_valid || phase.ready;
  assign req.ready = (pc == ST_IDLE) && !rst;

  always_comb begin
    case (uc.cond)
      COND_NEVER:     cond_true = 1'b0;
      COND_ALWAYS:    cond_true = 1'b1;
      COND_NO_REQ:    cond_true = !req.valid;
      COND_DIV_BUSY:  cond_true = div_busy;
      COND_SHORT:     cond_true = short_move;
      COND_D_ZERO:    cond_true = (dval == 24'd0);
      COND_EMIT_MORE: cond_true = !(emit_load && ph == PH_TAIL);
      default:        cond_true = 1'b0;
    endcase
    pc_next = cond_true ? uc.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  always_comb begin
    div_start = 1'b0;
    div_a_in  = CALC_W'(steps);
    div_d_in  = DIV_W'(spu);
    case (uc.op)
      OP_DIV_UPD: begin
        div_start = 1'b1;
      end
      OP_DIV_NJ: begin
        div_start = 1'b1;
        div_a_in  = CALC_W'(max_accel);
        div_d_in  = DIV_W'(jv);
      end
      OP_DIV_ROOM: begin
        div_start = 1'b1;
        div_a_in  = room[CALC_W-1] ? '0 : room;
        div_d_in  = dval;
      end
      default: ;
    endcase
  end

  assign div_trial = {div_r, div_q[CALC_W-1]};
  assign div_busy  = (div_cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      div_cnt <= CNT_W'(CALC_W);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_q <= div_a_in;
      div_r <= '0;
      div_d <= div_d_in;
    end else if (div_busy) begin
      if (div_trial >= {1'b0, div_d}) begin
        div_r <= DIV_W'(div_trial - {1'b0, div_d});
        div_q <= {div_q[CALC_W-2:0], 1'b1};
      end else begin
        div_r <= div_trial[DIV_W-1:0];
        div_q <= {div_q[CALC_W-2:0], 1'b0};
      end
    end
  end

  // datapath
  assign nm1        = (nj == 16'd0) ? 16'd0 : nj - 16'd1;
  assign nn_prod    = nj * nm1;
  assign tri_prod   = jv * nn[31:1];
  assign d_prod     = jv * nj;
  assign namax_prod = nj * max_accel;
  assign nad_prod   = na * dval;
  assign nd_prod    = nj * dval;

  assign upd_x  = SX_W'(upd);
  assign used_x = SX_W'({nj, 2'b00});
  assign qb_x   = (upd_x + SX_W'(3)) >> 2;
  assign nb_x   = (upd_x - used_x + SX_W'(1)) >> 1;
  assign acc_x  = SX_W'({na, 1'b0}) + used_x;

  always_ff @(posedge clk) begin
    case (uc.op)
      OP_LOAD: begin
        steps <= req.total_step_count;
        dir   <= req.move_direction;
      end
      OP_GET_UPD: begin
        upd        <= div_q[STEP_BITS-1:0];
        rem        <= div_r[7:0];
        short_move <= (div_q == '0);
      end
      OP_GET_NJ: begin
        nj <= (qb_x < SX_W'(div_q[15:0])) ? qb_x[15:0] : div_q[15:0];
      end
      OP_MUL_NN:    nn      <= nn_prod;
      OP_TRI:       tri_sum <= CALC_W'(tri_prod);
      OP_D:         dval    <= d_prod;
      OP_MUL_NAMAX: namax   <= namax_prod;
      OP_MARGIN: begin
        margin <= CALC_W'(namax) - tri_sum;
        f1     <= CALC_W'(min_rate) + tri_sum;
      end
      OP_ROOM: begin
        room <= CALC_W'(max_rate) - margin - f1;
        nb   <= (upd_x > used_x) ? nb_x[STEP_BITS-1:0] : '0;
      end
      OP_GET_NA: begin
        na <= (div_q < CALC_W'(nb)) ? div_q[STEP_BITS-1:0] : nb;
      end
      OP_NA_FLAT: na  <= room[CALC_W-1] ? '0 : nb;
      OP_MUL_NAD: nad <= CALC_W'(nad_prod);
      OP_MUL_ND:  nd  <= CALC_W'(nd_prod);
      OP_F2:      f2  <= f1 + nad;
      OP_F3:      f3  <= f2 + nd - tri_sum;
      OP_F4: begin
        f4 <= f3 - tri_sum;
        nc <= (upd_x > acc_x) ? STEP_BITS'(upd_x - acc_x) : '0;
      end
      OP_F5:      f5  <= f4 - nad;
      default: ;
    endcase
  end

  // phase selection
  assign d_pos = {1'b0, dval[15:0]};
  assign d_neg = 17'd0 - d_pos;
  assign j_pos = {1'b0, jv};
  assign j_neg = 9'd0 - j_pos;

  always_comb begin
    sel_rate  = CALC_W'(min_rate);
    sel_accel = '0;
    sel_jerk  = '0;
    sel_count = '0;
    if (ph == PH_TAIL) begin
      sel_count = STEP_BITS'(rem);
    end else if (!short_move) begin
      case (ph)
        PH_J1: begin
          sel_jerk  = j_pos;
          sel_count = STEP_BITS'(nj);
        end
        PH_A1: begin
          sel_rate  = f1;
          sel_accel = d_pos;
          sel_count = na;
        end
        PH_J2: begin
          sel_rate  = f2;
          sel_accel = d_pos;
          sel_jerk  = j_neg;
          sel_count = STEP_BITS'(nj);
        end
        PH_CRUISE: begin
          sel_rate  = f3;
          sel_count = nc;
        end
        PH_J3: begin
          sel_rate  = f3;
          sel_jerk  = j_neg;
          sel_count = STEP_BITS'(nj);
        end
        PH_A2: begin
          sel_rate  = f4;
          sel_accel = d_neg;
          sel_count = na;
        end
        PH_J4: begin
          sel_rate  = f5;
          sel_accel = d_neg;
          sel_jerk  = j_pos;
          sel_count = STEP_BITS'(nj);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ph        <= PH_J1;
    end else if (uc.op == OP_EMIT && emit_load) begin
      out_valid <= 1'b1;
      ph        <= ph + 1'b1;
    end else if (phase.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.op == OP_EMIT && emit_load) begin
      out_code  <= ph;
      out_rate  <= sel_rate[RATE_BITS-1:0];
      out_accel <= sel_accel;
      out_jerk  <= sel_jerk;
      out_count <= sel_count;
      out_tail  <= (rem != 8'd0);
      out_dir   <= dir;
      out_last  <= (ph == PH_TAIL);
    end
  end

  assign phase.valid         = out_valid;
  assign phase.phase_code    = out_code;
  assign phase.start_rate    = out_rate;
  assign phase.start_accel   = out_accel;
  assign phase.phase_jerk    = out_jerk;
  assign phase.update_count  = out_count;
  assign phase.tail_present  = out_tail;
  assign phase.direction_out = out_dir;
  assign phase.last_phase    = out_last;

endmodule

FILE: src/scmp_checker.sv
// port-level assertions of the s-curve planner and their bind
module scmp_checker #(
  parameter int STEP_BITS = 32,
  parameter int RATE_BITS = 21
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 phase_valid,
  input logic                 phase_ready,
  input logic [2:0]           phase_code,
  input logic [RATE_BITS-1:0] start_rate,
  input logic [16:0]          start_accel,
  input logic [8:0]           phase_jerk,
  input logic [STEP_BITS-1:0] update_count,
  input logic                 tail_present,
  input logic                 direction_out,
  input logic                 last_phase
);
  import scmp_pkg::*;

  // stalled transfer holds
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    phase_valid && !phase_ready |=> phase_valid && $stable({phase_code, start_rate,
      start_accel, phase_jerk, update_count, tail_present, direction_out, last_phase}))
    else $error("phase transfer changed while stalled");

  // a request keeps the planner busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while planning");

  // last flag marks the tail only
  a_last_is_tail: assert property (@(posedge clk) disable iff (rst)
    phase_valid |-> (last_phase == (phase_code == PH_TAIL)))
    else $error("last_phase not on tail");

  // no remainder, no tail steps
  a_empty_tail: assert property (@(posedge clk) disable iff (rst)
    phase_valid && phase_code == PH_TAIL && !tail_present |-> update_count == '0)
    else $error("tail steps without remainder");

endmodule

bind s_curve_motion_planner_core scmp_checker #(
  .STEP_BITS(STEP_BITS),
  .RATE_BITS(RATE_BITS)
) u_scmp_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .phase_valid  (phase.valid),
  .phase_ready  (phase.ready),
  .phase_code   (phase.phase_code),
  .start_rate   (phase.start_rate),
  .start_accel  (phase.start_accel),
  .phase_jerk   (phase.phase_jerk),
  .update_count (phase.update_count),
  .tail_present (phase.tail_present),
  .direction_out(phase.direction_out),
  .last_phase   (phase.last_phase)
);
